FILE: hdl/ufm_pkg.sv
// Shared types and constants for the union-find merge block.
package ufm_pkg;

  // Fixed field widths
  localparam int ELEM_W           = 10;
  localparam int RANK_W           = 4;
  localparam int DEF_NUM_ELEMENTS = 1024;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIMB,
    ST_COMP,
    ST_CMP,
    ST_RANK_A,
    ST_RANK_B,
    ST_DONE
  } ufm_state_e;

  // Parent memory read address source
  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_X,
    RD_NEXT
  } ufm_rd_sel_e;

  // Rank memory read address source
  typedef enum logic {
    RK_RA,
    RK_ROOT
  } ufm_rk_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic        clr_en;
    logic        load_en;
    ufm_rd_sel_e rd_sel;
    logic        x_ld;
    logic        root_ld;
    logic        ra_ld;
    logic        comp_wr;
    ufm_rk_sel_e rk_sel;
    logic        rank_a_ld;
    logic        link_en;
  } ufm_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic in_range;
    logic root_hit;
    logic at_start;
    logic next_is_root;
    logic same_root;
  } ufm_stat_t;

endpackage

FILE: hdl/ufm_dp.sv
// Datapath: parent and rank memories, walk registers and link logic.
module ufm_dp import ufm_pkg::*; #(
  parameter int NUM_ELEMENTS = DEF_NUM_ELEMENTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ELEM_W-1:0] elem_a_i,
  input  logic [ELEM_W-1:0] elem_b_i,
  input  ufm_cmd_t          cmd_i,
  output ufm_stat_t         stat_o
);

  localparam int IW = $clog2(NUM_ELEMENTS);
  localparam int CW = (IW > ELEM_W) ? IW : ELEM_W;

  logic [IW-1:0]     parent_mem [NUM_ELEMENTS];
  logic [RANK_W-1:0] rank_mem   [NUM_ELEMENTS];

  logic [IW-1:0]     node_q, x_q, b_q, root_q, ra_q, prd_q;
  logic [IW-1:0]     clr_q, clr_d;
  logic [RANK_W-1:0] rank_a_q, rrd_q;

  logic [CW-1:0]     a_ext, b_ext;
  logic [IW-1:0]     a_idx, b_idx, raddr, rk_raddr;
  logic              p_we, r_we;
  logic [IW-1:0]     p_waddr, p_wdata, r_waddr;
  logic [RANK_W-1:0] r_wdata;

  // Index range check on the request ports
  assign a_ext = CW'(elem_a_i);
  assign b_ext = CW'(elem_b_i);
  assign a_idx = a_ext[IW-1:0];
  assign b_idx = b_ext[IW-1:0];

  assign stat_o.in_range = ({1'b0, a_ext} < (CW+1)'(NUM_ELEMENTS)) &&
                           ({1'b0, b_ext} < (CW+1)'(NUM_ELEMENTS));

  // Parent read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_A:    raddr = a_idx;
      RD_B:    raddr = b_q;
      RD_X:    raddr = x_q;
      RD_NEXT: raddr = prd_q;
      default: raddr = prd_q;
    endcase
  end

  assign rk_raddr = (cmd_i.rk_sel == RK_ROOT) ? root_q : ra_q;

  // Write ports: clearing sweep, path compression, or root link
  always_comb begin
    p_we    = 1'b0;
    p_waddr = node_q;
    p_wdata = root_q;
    r_we    = 1'b0;
    r_waddr = ra_q;
    r_wdata = rank_a_q + RANK_W'(1);
    if (cmd_i.clr_en) begin
      p_we    = 1'b1;
      p_waddr = clr_q;
      p_wdata = clr_q;
      r_we    = 1'b1;
      r_waddr = clr_q;
      r_wdata = '0;
    end else if (cmd_i.comp_wr) begin
      p_we = 1'b1;
    end else if (cmd_i.link_en) begin
      p_we = 1'b1;
      if (rank_a_q < rrd_q) begin
        // b's root has higher rank and survives
        p_waddr = ra_q;
        p_wdata = root_q;
      end else begin
        p_waddr = root_q;
        p_wdata = ra_q;
        r_we    = (rank_a_q == rrd_q) && (rank_a_q != '1);
      end
    end
  end

  // Parent memory, with write data forwarded on a same-address read
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    if (p_we && (p_waddr == raddr)) begin
      prd_q <= p_wdata;
    end else begin
      prd_q <= parent_mem[raddr];
    end
  end

  // Rank memory
  always_ff @(posedge clk_i) begin
    if (r_we) begin
      rank_mem[r_waddr] <= r_wdata;
    end
    rrd_q <= rank_mem[rk_raddr];
  end

  // Clearing sweep counter
  assign clr_d = cmd_i.clr_en ? clr_q + IW'(1) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // Walk registers
  always_ff @(posedge clk_i) begin
    node_q <= raddr;
    if (cmd_i.x_ld)      x_q      <= raddr;
    if (cmd_i.load_en)   b_q      <= b_idx;
    if (cmd_i.root_ld)   root_q   <= node_q;
    if (cmd_i.ra_ld)     ra_q     <= node_q;
    if (cmd_i.rank_a_ld) rank_a_q <= rrd_q;
  end

  // Status
  assign stat_o.clr_done     = (clr_q == IW'(NUM_ELEMENTS - 1));
  assign stat_o.root_hit     = (prd_q == node_q);
  assign stat_o.at_start     = (node_q == x_q);
  assign stat_o.next_is_root = (prd_q == root_q);
  assign stat_o.same_root    = (ra_q == root_q);

endmodule

FILE: hdl/ufm_ctrl.sv
// Controller: sequences clearing, root walks, compression, link and result.
module ufm_ctrl import ufm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      joined_o,
  input  ufm_stat_t stat_i,
  output ufm_cmd_t  cmd_o
);

  ufm_state_e state_q, state_d;
  logic       phase_q, phase_d;     // 0: walking from a, 1: walking from b
  logic       res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic       out_joined_q, out_joined_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = stat_i.in_range ? ST_CLIMB : ST_DONE;
      end
      ST_CLIMB: begin
        if (stat_i.root_hit) begin
          if (!stat_i.at_start) state_d = ST_COMP;
          else if (phase_q)     state_d = ST_CMP;
        end
      end
      ST_COMP: begin
        if (stat_i.next_is_root) state_d = phase_q ? ST_CMP : ST_CLIMB;
      end
      ST_CMP: begin
        state_d = stat_i.same_root ? ST_DONE : ST_RANK_A;
      end
      ST_RANK_A: state_d = ST_RANK_B;
      ST_RANK_B: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_NEXT;
    cmd_o.rk_sel = RK_RA;
    in_ready_o   = 1'b0;
    phase_d      = phase_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_joined_d = out_joined_q;
    case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.rd_sel = RD_A;
        if (in_valid_i) begin
          cmd_o.load_en = 1'b1;
          cmd_o.x_ld    = 1'b1;
          phase_d       = 1'b0;
          res_d         = 1'b0;
        end
      end
      ST_CLIMB: begin
        if (stat_i.root_hit) begin
          cmd_o.root_ld = 1'b1;
          cmd_o.ra_ld   = !phase_q;
          if (!stat_i.at_start) begin
            cmd_o.rd_sel = RD_X;
          end else if (!phase_q) begin
            cmd_o.rd_sel = RD_B;
            cmd_o.x_ld   = 1'b1;
            phase_d      = 1'b1;
          end
        end
      end
      ST_COMP: begin
        cmd_o.comp_wr = 1'b1;
        if (stat_i.next_is_root && !phase_q) begin
          cmd_o.rd_sel = RD_B;
          cmd_o.x_ld   = 1'b1;
          phase_d      = 1'b1;
        end
      end
      ST_CMP: begin
        cmd_o.rk_sel = RK_RA;
        res_d        = 1'b0;
      end
      ST_RANK_A: begin
        cmd_o.rk_sel    = RK_ROOT;
        cmd_o.rank_a_ld = 1'b1;
      end
      ST_RANK_B: begin
        cmd_o.link_en = 1'b1;
        res_d         = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_joined_d = res_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q        <= res_d;
    out_joined_q <= out_joined_d;
  end

  assign out_valid_o = out_valid_q;
  assign joined_o    = out_joined_q;

endmodule

FILE: hdl/union_find_merge.sv
// Top level of the union-find merge block: controller plus datapath.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   in      | in_valid_i, in_ready_o, elem_a_i,  | request in
//           | elem_b_i                          |
//   out     | out_valid_o, out_ready_i, joined_o| result out
//
// One request at a time. A request walks from a to its root and compresses that path,
// then does the same from b, and links the two roots when they differ; the number of
// nodes compressed on each walk equals its climb length to the root. A request naming
// an element out of range goes straight to the result. Each walk step is one read of
// the single-read-port parent memory. After reset a clearing pass sets every parent to
// itself and every rank to zero; no request is taken meanwhile.
// A stalled result sits in the output register; the next request is still taken,
// and its result then waits, holding off the input, until the first one leaves.
module union_find_merge import ufm_pkg::*; #(
  parameter int NUM_ELEMENTS = DEF_NUM_ELEMENTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ELEM_W-1:0] elem_a_i,
  input  logic [ELEM_W-1:0] elem_b_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              joined_o
);

  ufm_cmd_t  cmd;
  ufm_stat_t stat;

  ufm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .joined_o    (joined_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ufm_dp #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .elem_a_i (elem_a_i),
    .elem_b_i (elem_b_i),
    .cmd_i    (cmd),
    .stat_o   (stat)
  );

endmodule
